@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing when SYNTH is
// defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/dhp_pkg.sv @@
// ---------------------------------------------------------------------------
// dhp_pkg
// Types and constants shared by the depth histogram percentile modules.
// ---------------------------------------------------------------------------
package dhp_pkg;

    // Default sizes for the histogram.
    localparam int DEPTH_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed field widths.
    localparam int BYTE_BITS  = 8;
    localparam int VALUE_BITS = 16;
    localparam int FRAC_BITS  = 17;
    localparam int OUT_BITS   = 32;
    localparam int Q_BITS     = 16;
    localparam int Q16_ONE    = 65536;

    // Step counter of the bit-serial multiplier.
    localparam int MUL_CNT_W  = $clog2(FRAC_BITS);

    // Operation codes of an input item.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_write;
        logic pix_accept;
        logic pix_write;
        logic q_accept;
        logic mul_step;
        logic tgt_load;
        logic scan_run;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic raw_zero;
        logic total_zero;
        logic clr_last;
        logic mul_last;
        logic scan_hit;
        logic out_free;
    } sts_t;

endpackage

@@ src/depth_histogram_percentile_core.sv @@
// ---------------------------------------------------------------------------
// depth_histogram_percentile_core
// Depth pixel histogram with saturating counters and percentile queries.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  ------------------------------------------
//  in       input      in_valid / in_stall   operation, first_byte, second_byte,
//                                            fraction_q16
//  out      output     out_valid / out_stall percentile_value, valid_count, invalid_count
//  cfg      input      cfg_valid / cfg_ready cfg_data (big_endian)
//
//  A zero pixel is only counted in the invalid total; a nonzero pixel reads its bin, then writes it back.
//  A query runs through the accept, 17 multiplier steps, a target load, a scan of the
//  bins from bin 1 up to the hit, and a result load. With no valid pixels a query goes
//  from its accept straight to the result load. After reset a clearing pass over all
//  2^DEPTH_BITS bins keeps in_stall high; configuration writes are taken at any time.
//  A waiting result holds back only the result load of the next query, with in_stall high.
//
module depth_histogram_percentile_core
    import dhp_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,

    // Input item channel.
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [BYTE_BITS-1:0]  first_byte,
    input  logic [BYTE_BITS-1:0]  second_byte,
    input  logic [FRAC_BITS-1:0]  fraction_q16,

    // Result item channel.
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] percentile_value,
    output logic [OUT_BITS-1:0]   valid_count,
    output logic [OUT_BITS-1:0]   invalid_count
);

    cmd_t cmd;
    sts_t sts;

    // The byte-order register can be written in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences each item; it only sees in_valid, the operation code and
    // the status flags, never the rest of the payload.
    dhp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the histogram memory, the pixel totals, the target
    // multiplier, the scan accumulator and the output register.
    dhp_datapath #(
        .DEPTH_BITS (DEPTH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .first_byte       (first_byte),
        .second_byte      (second_byte),
        .fraction_q16     (fraction_q16),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .percentile_value (percentile_value),
        .valid_count      (valid_count),
        .invalid_count    (invalid_count),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

@@ src/dhp_ctrl.sv @@
// ---------------------------------------------------------------------------
// dhp_ctrl
// Sequencer for the clearing pass, pixel updates and percentile queries.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dhp_ctrl
    import dhp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic operation,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_PIX_WR = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_TGT    = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_PIXEL)
                    begin
                        cmd.pix_accept = 1'b1;
                        if (!sts.raw_zero)
                        begin
                            state_next = S_PIX_WR;
                        end
                    end
                    else
                    begin
                        cmd.q_accept = 1'b1;
                        state_next   = sts.total_zero ? S_DONE : S_MUL;
                    end
                end
            end
            S_PIX_WR:
            begin
                cmd.pix_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    state_next = S_TGT;
                end
            end
            S_TGT:
            begin
                cmd.tgt_load = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_load_needs_slot, clk, rst_n, cmd.out_load, sts.out_free, "result loaded into a full output register")

endmodule

@@ src/dhp_datapath.sv @@
// ---------------------------------------------------------------------------
// dhp_datapath
// Histogram memory, pixel counters, bit-serial target multiplier, bin scan
// and the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dhp_datapath
    import dhp_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_data,
    input  logic [BYTE_BITS-1:0]  first_byte,
    input  logic [BYTE_BITS-1:0]  second_byte,
    input  logic [FRAC_BITS-1:0]  fraction_q16,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [VALUE_BITS-1:0] percentile_value,
    output logic [OUT_BITS-1:0]   valid_count,
    output logic [OUT_BITS-1:0]   invalid_count,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int NUM_BINS = 1 << DEPTH_BITS;
    localparam int TOP_BIN  = NUM_BINS - 1;
    localparam int PROD_W   = COUNT_BITS + FRAC_BITS;
    localparam int SUM_W    = COUNT_BITS + DEPTH_BITS;
    localparam int EXT_W    = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

    // Histogram memory and its registered read port.
    logic [COUNT_BITS-1:0] mem [NUM_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  mem_we;
    logic [DEPTH_BITS-1:0] mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [DEPTH_BITS-1:0] mem_raddr;

    logic                  big_endian_reg;
    logic [COUNT_BITS-1:0] valid_total_reg;
    logic [COUNT_BITS-1:0] invalid_total_reg;
    logic [DEPTH_BITS-1:0] clr_addr_reg;
    logic [DEPTH_BITS-1:0] pix_bin_reg;

    logic [FRAC_BITS-1:0]  frac_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [MUL_CNT_W-1:0]  mul_cnt_reg;
    logic [COUNT_BITS-1:0] target_reg;

    logic [DEPTH_BITS-1:0] scan_addr_reg;
    logic                  scan_issue_done_reg;
    logic                  scan_pv_reg;
    logic [DEPTH_BITS-1:0] scan_bin_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [DEPTH_BITS-1:0] res_bin_reg;

    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] pct_out_reg;
    logic [OUT_BITS-1:0]   vcnt_out_reg;
    logic [OUT_BITS-1:0]   icnt_out_reg;

    logic [VALUE_BITS-1:0] raw;
    logic [DEPTH_BITS-1:0] pix_bin;
    logic [FRAC_BITS-1:0]  frac_clamped;
    logic [PROD_W-1:0]     tgt_wide;
    logic [SUM_W-1:0]      sum_next;
    logic                  scan_issue;
    logic [EXT_W-1:0]      vtot_ext;
    logic [EXT_W-1:0]      itot_ext;
    logic [OUT_BITS-1:0]   vtot_sat;
    logic [OUT_BITS-1:0]   itot_sat;
    logic                  out_free;

    // Pixel value, clamped into the top bin when it lies beyond the bins.
    assign raw     = big_endian_reg ? {first_byte, second_byte} : {second_byte, first_byte};
    assign pix_bin = (raw > VALUE_BITS'(TOP_BIN)) ? DEPTH_BITS'(TOP_BIN)
                                                  : raw[DEPTH_BITS-1:0];

    assign frac_clamped = (fraction_q16 > FRAC_BITS'(Q16_ONE)) ? FRAC_BITS'(Q16_ONE)
                                                               : fraction_q16;

    // Ceiling of the Q16 product.
    assign tgt_wide = (prod_reg >> Q_BITS) + PROD_W'(|prod_reg[Q_BITS-1:0]);

    assign sum_next   = sum_reg + SUM_W'(rd_data_reg);
    assign scan_issue = cmd.scan_run && !scan_issue_done_reg;

    assign vtot_ext = EXT_W'(valid_total_reg);
    assign itot_ext = EXT_W'(invalid_total_reg);
    assign vtot_sat = (vtot_ext > EXT_W'({OUT_BITS{1'b1}})) ? '1 : vtot_ext[OUT_BITS-1:0];
    assign itot_sat = (itot_ext > EXT_W'({OUT_BITS{1'b1}})) ? '1 : itot_ext[OUT_BITS-1:0];

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts.raw_zero   = (raw == '0);
        sts.total_zero = (valid_total_reg == '0);
        sts.clr_last   = (clr_addr_reg == DEPTH_BITS'(TOP_BIN));
        sts.mul_last   = (mul_cnt_reg == '0);
        sts.scan_hit   = scan_pv_reg && ((sum_next >= SUM_W'(target_reg)) ||
                                         (scan_bin_reg == DEPTH_BITS'(TOP_BIN)));
        sts.out_free   = out_free;
    end

    // Memory port selection.
    always_comb
    begin
        mem_we    = cmd.clr_write || cmd.pix_write;
        mem_waddr = cmd.clr_write ? clr_addr_reg : pix_bin_reg;
        mem_wdata = (cmd.clr_write || (rd_data_reg == '1)) ? (cmd.clr_write ? '0 : rd_data_reg)
                                                           : rd_data_reg + COUNT_BITS'(1);
        mem_re    = (cmd.pix_accept && !sts.raw_zero) || scan_issue;
        mem_raddr = cmd.pix_accept ? pix_bin : scan_addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg      <= 1'b0;
            valid_total_reg     <= '0;
            invalid_total_reg   <= '0;
            clr_addr_reg        <= '0;
            mul_cnt_reg         <= '0;
            scan_issue_done_reg <= 1'b0;
            scan_pv_reg         <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                big_endian_reg <= cfg_data;
            end
            if (cmd.clr_write)
            begin
                clr_addr_reg <= clr_addr_reg + DEPTH_BITS'(1);
            end
            if (cmd.pix_accept)
            begin
                if (sts.raw_zero)
                begin
                    if (invalid_total_reg != '1)
                    begin
                        invalid_total_reg <= invalid_total_reg + COUNT_BITS'(1);
                    end
                end
                else if (valid_total_reg != '1)
                begin
                    valid_total_reg <= valid_total_reg + COUNT_BITS'(1);
                end
            end
            if (cmd.q_accept)
            begin
                mul_cnt_reg <= MUL_CNT_W'(FRAC_BITS - 1);
            end
            else if (cmd.mul_step)
            begin
                mul_cnt_reg <= mul_cnt_reg - MUL_CNT_W'(1);
            end
            if (cmd.tgt_load)
            begin
                scan_issue_done_reg <= 1'b0;
                scan_pv_reg         <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                scan_pv_reg <= scan_issue;
                if (scan_issue && (scan_addr_reg == DEPTH_BITS'(TOP_BIN)))
                begin
                    scan_issue_done_reg <= 1'b1;
                end
            end
            if (out_free)
            begin
                out_valid_reg <= cmd.out_load;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.pix_accept)
        begin
            pix_bin_reg <= pix_bin;
        end
        if (cmd.q_accept)
        begin
            frac_reg    <= frac_clamped;
            prod_reg    <= '0;
            res_bin_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            // One multiplier bit per cycle, most significant first.
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0} +
                        (frac_reg[FRAC_BITS-1] ? PROD_W'(valid_total_reg) : '0);
            frac_reg <= {frac_reg[FRAC_BITS-2:0], 1'b0};
        end
        if (cmd.tgt_load)
        begin
            target_reg    <= tgt_wide[COUNT_BITS-1:0];
            scan_addr_reg <= DEPTH_BITS'(1);
            sum_reg       <= '0;
        end
        else if (cmd.scan_run)
        begin
            if (scan_issue)
            begin
                scan_bin_reg  <= scan_addr_reg;
                scan_addr_reg <= scan_addr_reg + DEPTH_BITS'(1);
            end
            if (scan_pv_reg)
            begin
                sum_reg <= sum_next;
            end
            if (sts.scan_hit)
            begin
                res_bin_reg <= scan_bin_reg;
            end
        end
        if (cmd.out_load)
        begin
            pct_out_reg  <= VALUE_BITS'(res_bin_reg);
            vcnt_out_reg <= vtot_sat;
            icnt_out_reg <= itot_sat;
        end
    end

    assign out_valid        = out_valid_reg;
    assign percentile_value = pct_out_reg;
    assign valid_count      = vcnt_out_reg;
    assign invalid_count    = icnt_out_reg;

    `ASSERT_IMPLIES(a_write_after_read, clk, rst_n, cmd.pix_write, $past(cmd.pix_accept), "bin write without a preceding read")
    `ASSERT_ALWAYS(a_valid_total_grows, clk, rst_n, valid_total_reg >= $past(valid_total_reg), "valid total decreased")

endmodule
